// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
// types, constants and round functions for the sha-256 engine
package sha_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // queued word after the front end has classified it
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } cmd_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== rtl/sha_front.sv =====
// input side: saturates byte counts, drops empty words without last and queues the rest
module sha_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid_in,
  output logic             stall_in,
  input  sha_pkg::in_item_t item_in,
  output logic             q_valid,
  input  logic             q_pop,
  output sha_pkg::cmd_t    q_head
);
  import sha_pkg::*;

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   level;
  logic           push;
  logic           keep;
  logic [2:0]     cnt_sat;

  assign stall_in = (level == QAW'(0) + (QAW+1)'(QDEPTH));
  assign cnt_sat  = (item_in.byte_count > 3'd4) ? 3'd4 : item_in.byte_count;
  assign keep     = item_in.last || (cnt_sat != 3'd0);
  assign push     = valid_in && !stall_in && keep;
  assign q_valid  = (level != '0);
  assign q_head   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: item_in.message_word, count: cnt_sat, last: item_in.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      level <= level + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_pop_empty, q_pop && !q_valid)
  `ASSERT_NEVER(a_level_range, level > (QAW+1)'(QDEPTH))
  `ASSERT_IMPL(a_push_grows, push && !q_pop |=> level == $past(level) + (QAW+1)'(1))
endmodule

// ===== rtl/sha_back.sv =====
// back end: byte packing, padding, 64-round compression and digest output
module sha_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  sha_pkg::cmd_t     q_head,
  output logic              valid,
  input  logic              stall,
  output sha_pkg::out_item_t item
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PUT  = 6'b000010,
    S_PAD  = 6'b000100,
    S_INIT = 6'b001000,
    S_RND  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] blk [16];
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [63:0] msg_len;
  logic [5:0]  fill;
  logic [6:0]  rnd;
  logic [31:0] cur_data;
  logic [2:0]  cur_cnt;
  logic        cur_last;
  logic        padding;
  logic        pad_done;
  logic        len_ok;
  logic [2:0]  oidx;
  logic [31:0] wt;
  logic [31:0] wnew;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [7:0]  byte_sel;
  logic [7:0]  pad_byte;
  logic [63:0] bits;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign byte_sel = cur_data[31:24];
  assign bits     = {msg_len[60:0], 3'b000};
  assign wnew     = sig1(w[14]) + w[9] + sig0(w[1]) + w[0];
  assign wt       = (rnd < 7'd16) ? w[0] : wnew;
  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd[5:0]] + wt;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // length bytes only go into the block that has room for them
  always_comb begin
    pad_byte = 8'h00;
    if (!pad_done) begin
      pad_byte = PAD_BYTE;
    end else if (len_ok && fill >= 6'd56) begin
      pad_byte = bits[8'd63 - 8'({fill[2:0], 3'b000}) -: 8];
    end
  end

  assign valid = (state == S_OUT);
  assign item  = '{digest_word: h[oidx], word_index: oidx, last_word: (oidx == 3'd7)};

  always_ff @(posedge clk) begin
    case (state)
      S_PUT: begin
        if (cur_cnt != 3'd0) begin
          blk[fill[5:2]][8'd31 - 8'({fill[1:0], 3'b000}) -: 8] <= byte_sel;
        end
      end
      S_PAD: begin
        blk[fill[5:2]][8'd31 - 8'({fill[1:0], 3'b000}) -: 8] <= pad_byte;
      end
      default: begin
      end
    endcase
    if (state == S_INIT) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (state == S_RND && rnd < 7'd64) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      msg_len  <= '0;
      fill     <= '0;
      rnd      <= '0;
      padding  <= 1'b0;
      pad_done <= 1'b0;
      len_ok   <= 1'b0;
      oidx     <= '0;
      cur_cnt  <= '0;
      cur_last <= 1'b0;
      cur_data <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_data <= q_head.data;
            cur_cnt  <= q_head.count;
            cur_last <= q_head.last;
            state    <= S_PUT;
          end
        end
        S_PUT: begin
          if (cur_cnt == 3'd0) begin
            if (cur_last) begin
              padding  <= 1'b1;
              pad_done <= 1'b0;
              state    <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            cur_data <= {cur_data[23:0], 8'h00};
            cur_cnt  <= cur_cnt - 3'd1;
            msg_len  <= msg_len + 64'd1;
            fill     <= fill + 6'd1;
            if (fill == 6'd63) begin
              state <= S_INIT;
            end
          end
        end
        S_PAD: begin
          pad_done <= 1'b1;
          fill     <= fill + 6'd1;
          if (!pad_done) begin
            len_ok <= (fill < 6'd56);
          end
          if (fill == 6'd63) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          rnd   <= '0;
          state <= S_RND;
        end
        S_RND: begin
          if (rnd == 7'd64) begin
            for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
            if (!padding) begin
              state <= S_PUT;
            end else if (len_ok) begin
              state <= S_OUT;
              oidx  <= '0;
            end else begin
              len_ok <= 1'b1;
              state  <= S_PAD;
            end
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_OUT: begin
          if (!stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
              msg_len  <= '0;
              padding  <= 1'b0;
              pad_done <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_pop_busy, q_pop && state != S_IDLE)
  `ASSERT_IMPL(a_out_hold, valid && stall |=> valid && item == $past(item))
  `ASSERT_IMPL(a_rounds, state == S_INIT |=> state == S_RND && rnd == 7'd0)
endmodule

// ===== rtl/sha256_hash_engine_core.sv =====
// top level of the sha-256 engine
// usage:
//   input channel (valid_in, stall_in, item_in): one message word per item,
//   up to four bytes from the top, byte_count saturated at four, last marks
//   the end of the message. words with no bytes and no last are dropped.
//   output channel (valid, stall, item): eight digest words per message,
//   word_index 0 first, last_word on the eighth.
// operation:
//   the input queue holds four words; the back end fetches each word,
//   packs its bytes one at a time and then finishes it; each full block
//   is loaded, run through 64 rounds and added to the chain value. the
//   back end takes the next word only once it is back in idle.
//   the final word adds padding of 9 to 72 bytes and one or two
//   compressions, then the eight digest words are output.
// reset: chain value returns to the initial hash, counts and queue clear.
// a stalled output holds its word; the back end then waits and the input
// queue fills, after which stall_in rises.
module sha256_hash_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  output logic               stall_in,
  input  sha_pkg::in_item_t  item_in,
  output logic               valid,
  input  logic               stall,
  output sha_pkg::out_item_t item
);
  import sha_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_head;

  sha_front u_front (
    .clk, .rst, .valid_in, .stall_in, .item_in,
    .q_valid, .q_pop, .q_head
  );

  sha_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head,
    .valid, .stall, .item
  );
endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the sha-256 hash engine: predicted digests checked word by word
`timescale 1ns / 1ps

class digest_board;
  sha_pkg::out_item_t pending_words[$];
  int unsigned mismatches;
  logic [31:0] chain [8];
  logic [7:0]  block [64];
  int unsigned fill;
  logic [63:0] msg_bytes;

  function void clear_message();
    for (int j = 0; j < 8; j++) chain[j] = sha_pkg::INIT_H[j];
    fill = 0;
    msg_bytes = '0;
  endfunction

  function new();
    mismatches = 0;
    clear_message();
  endfunction

  function logic [31:0] ror(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, x2, x15;
    for (int t = 0; t < 16; t++)
      w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x2 = w[(t-2) & 15];
        x15 = w[(t-15) & 15];
        s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
        s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
        w[t & 15] = s1 + w[(t-7) & 15] + s0 + w[t & 15];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endfunction

  function void add_byte(logic [7:0] b);
    block[fill] = b;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  function void note_word(sha_pkg::in_item_t it);
    int unsigned n;
    logic [63:0] bits;
    sha_pkg::out_item_t o;
    n = (it.byte_count > 4) ? 4 : it.byte_count;
    for (int i = 0; i < n; i++) begin
      add_byte(it.message_word[31 - 8*i -: 8]);
      msg_bytes++;
    end
    if (!it.last) return;
    bits = msg_bytes << 3;
    block[fill] = sha_pkg::PAD_BYTE;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin block[fill] = 8'h00; fill++; end
      compress();
      fill = 0;
    end
    while (fill < 56) begin block[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) block[56 + i] = bits[63 - 8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index = i[2:0];
      o.last_word = (i == 7);
      pending_words = {pending_words, o};
    end
    clear_message();
  endfunction

  function void check_word(sha_pkg::out_item_t got);
    sha_pkg::out_item_t exp_word;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected digest word %h", got);
      return;
    end
    exp_word = pending_words.pop_front();
    if (got !== exp_word) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digest word: expected %h/%0d/%0d got %h/%0d/%0d",
                 exp_word.digest_word, exp_word.word_index, exp_word.last_word,
                 got.digest_word, got.word_index, got.last_word);
    end
  endfunction
endclass

module tb_top;
  import sha_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic stall_in;
  in_item_t item_in = '0;
  logic valid;
  logic stall = 1'b0;
  out_item_t item;

  digest_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int unsigned quiet_cycles = 0;
  bit done = 1'b0;

  sha256_hash_engine_core u_dut (
    .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in), .item_in(item_in),
    .valid(valid), .stall(stall), .item(item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (valid_in && !stall_in) board.note_word(item_in);
      if (valid && !stall) board.check_word(item);
      if ((valid_in && !stall_in) || (valid && !stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000 && !done) begin
        $display("sha256_hash_engine_core: mismatch");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_recv) stall <= 1'b1;
    else stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(logic [31:0] w, logic [2:0] n, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_in <= 1'b0;
      @(posedge clk);
    end
    valid_in <= 1'b1;
    item_in <= '{message_word: w, byte_count: n, last: l};
    @(posedge clk);
    while (stall_in) @(posedge clk);
  endtask

  task automatic send_message(int unsigned words);
    logic [2:0] n;
    for (int i = 0; i < words; i++) begin
      n = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
      if (n == 0 && i != words - 1) n = 3'd4;
      send_word($urandom, n, i == words - 1);
    end
  endtask

  task automatic drain();
    valid_in <= 1'b0;
    @(posedge clk);
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'hffffffff, 3'd7, 1'b0);
    send_word(32'h12345678, 3'd5, 1'b1);
    for (int i = 0; i < 14; i++) send_word(32'ha5a55a5a, 3'd4, i == 13);
    send_word(32'h00000000, 3'd1, 1'b0);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'h80000000, 3'd6, 1'b1);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 80 : 22) : 0;
      recv_stall_pct = (ph == 2) ? 80 : ((ph == 3) ? 22 : 0);
      for (int m = 0; m < 6; m++)
        send_message(($urandom_range(3) == 0) ? $urandom_range(17, 34)
                                              : $urandom_range(1, 10));
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int m = 0; m < 5; m++) send_message($urandom_range(1, 6));
    join
    drain();
    repeat (300) @(posedge clk);
    done = 1'b1;
    if (board.mismatches == 0 && board.pending_words.size() == 0)
      $display("sha256_hash_engine_core: match");
    else
      $display("sha256_hash_engine_core: mismatch");
    $finish;
  end
endmodule
